// ===== design/park_inverse_park_transform_defines.svh =====
// Assertion macros used by the Park transform design file.
`ifndef PARK_INVERSE_PARK_TRANSFORM_DEFINES_SVH
`define PARK_INVERSE_PARK_TRANSFORM_DEFINES_SVH

// Checks that a condition holds in every cycle outside reset.
`define PIPT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define PIPT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pipt_pkg.sv =====
// Package with types, constants, the sine table and the saturation function.
package pipt_pkg;

    typedef logic signed [15:0] t_q15;
    typedef logic signed [33:0] t_sum;

    localparam logic [14:0] COS_OFFSET = 15'd8192;
    localparam logic signed [16:0] STEP_LIMIT = 17'sd255;
    localparam t_sum SAT_LIMIT = 34'sh3fffffff;
    localparam t_q15 SAT_POS = 16'sh7fff;
    localparam t_q15 SAT_NEG = 16'sh8001;

    localparam logic [15:0] SINE_ROM [0:256] = '{
        16'd0, 16'd804, 16'd1609, 16'd2410, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
        16'd6393, 16'd7179, 16'd7962, 16'd8739, 16'd9512, 16'd10278, 16'd11039, 16'd11793,
        16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846,
        16'd17530, 16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403,
        16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279, 16'd24812, 16'd25329,
        16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683, 16'd28105, 16'd28510,
        16'd28898, 16'd29268, 16'd29621, 16'd29956, 16'd30273, 16'd30571, 16'd30852,
        16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971, 16'd32137, 16'd32285,
        16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757, 16'd32767,
        16'd32757, 16'd32728, 16'd32678, 16'd32609, 16'd32521, 16'd32412, 16'd32285,
        16'd32137, 16'd31971, 16'd31785, 16'd31580, 16'd31356, 16'd31113, 16'd30852,
        16'd30571, 16'd30273, 16'd29956, 16'd29621, 16'd29268, 16'd28898, 16'd28510,
        16'd28105, 16'd27683, 16'd27245, 16'd26790, 16'd26319, 16'd25832, 16'd25329,
        16'd24811, 16'd24279, 16'd23731, 16'd23170, 16'd22594, 16'd22005, 16'd21403,
        16'd20787, 16'd20159, 16'd19519, 16'd18868, 16'd18204, 16'd17530, 16'd16846,
        16'd16151, 16'd15446, 16'd14732, 16'd14010, 16'd13279, 16'd12538, 16'd11793,
        16'd11039, 16'd10278, 16'd9512, 16'd8739, 16'd7962, 16'd7179, 16'd6393,
        16'd5602, 16'd4808, 16'd4011, 16'd3212, 16'd2410, 16'd1608, 16'd804, 16'd0,
        16'd64731, 16'd63927, 16'd63125, 16'd62323, 16'd61524, 16'd60727, 16'd59933,
        16'd59142, 16'd58356, 16'd57573, 16'd56796, 16'd56023, 16'd55257, 16'd54496,
        16'd53742, 16'd52996, 16'd52256, 16'd51525, 16'd50803, 16'd50089, 16'd49384,
        16'd48689, 16'd48005, 16'd47331, 16'd46667, 16'd46016, 16'd45377, 16'd44748,
        16'd44132, 16'd43530, 16'd42941, 16'd42365, 16'd41804, 16'd41256, 16'd40724,
        16'd40206, 16'd39703, 16'd39216, 16'd38745, 16'd38290, 16'd37852, 16'd37430,
        16'd37025, 16'd36637, 16'd36267, 16'd35914, 16'd35579, 16'd35262, 16'd34964,
        16'd34682, 16'd34422, 16'd34179, 16'd33955, 16'd33750, 16'd33564, 16'd33398,
        16'd33250, 16'd33123, 16'd33014, 16'd32926, 16'd32857, 16'd32807, 16'd32778,
        16'd32769, 16'd32778, 16'd32807, 16'd32857, 16'd32926, 16'd33014, 16'd33123,
        16'd33250, 16'd33398, 16'd33564, 16'd33750, 16'd33955, 16'd34179, 16'd34422,
        16'd34683, 16'd34964, 16'd35262, 16'd35579, 16'd35914, 16'd36267, 16'd36637,
        16'd37025, 16'd37430, 16'd37852, 16'd38290, 16'd38745, 16'd39216, 16'd39703,
        16'd40206, 16'd40724, 16'd41256, 16'd41804, 16'd42365, 16'd42941, 16'd43530,
        16'd44132, 16'd44748, 16'd45376, 16'd46016, 16'd46667, 16'd47331, 16'd48005,
        16'd48689, 16'd49384, 16'd50089, 16'd50802, 16'd51525, 16'd52256, 16'd52996,
        16'd53742, 16'd54496, 16'd55257, 16'd56023, 16'd56796, 16'd57573, 16'd58356,
        16'd59142, 16'd59933, 16'd60727, 16'd61524, 16'd62323, 16'd63125, 16'd63927,
        16'd64731, 16'd65535
    };

    // Doubles the sum and takes its upper word, saturating large magnitudes.
    function automatic t_q15 scale_sat(input t_sum sum);
        t_q15 result;
        if (sum >= SAT_LIMIT) begin
            result = SAT_POS;
        end else if (sum <= -SAT_LIMIT) begin
            result = SAT_NEG;
        end else begin
            result = sum[30:15];
        end
        return result;
    endfunction

endpackage

// ===== design/park_inverse_park_transform.sv =====
// Park and inverse Park transform, pipelined from accepted start to o_valid.
// A new item may be started in every cycle; busy is always low.
// Stages: table read, interpolation product, sine and cosine add, four
// 16x16 products, then sum with saturation into the output register.
// Synchronous active-low reset clears the valid pipeline only.
`include "park_inverse_park_transform_defines.svh"

module park_inverse_park_transform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic signed [15:0]  i_first_in,
    input  logic signed [15:0]  i_second_in,
    input  logic [15:0]         i_angle,
    output logic                o_valid,
    output logic signed [15:0]  o_first_out,
    output logic signed [15:0]  o_second_out
);

    logic [4:0]         r_vld;
    logic [2:0]         r_kind;
    pipt_pkg::t_q15     r_a [0:2];
    pipt_pkg::t_q15     r_b [0:2];
    logic               r_kind4;
    logic signed [31:0] r_ac;
    logic signed [31:0] r_bs;
    logic signed [31:0] r_as;
    logic signed [31:0] r_bc;
    pipt_pkg::t_q15     r_first;
    pipt_pkg::t_q15     r_second;

    pipt_pkg::t_q15     w_sin;
    pipt_pkg::t_q15     w_cos;
    logic [14:0]        w_cos_angle;
    pipt_pkg::t_sum     n_sum_first;
    pipt_pkg::t_sum     n_sum_second;

    assign busy        = 1'b0;
    assign w_cos_angle = i_angle[14:0] + pipt_pkg::COS_OFFSET;

    pipt_sincos u_sin (
        .i_clk   (i_clk),
        .i_angle (i_angle[14:0]),
        .o_value (w_sin)
    );

    pipt_sincos u_cos (
        .i_clk   (i_clk),
        .i_angle (w_cos_angle),
        .o_value (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], start & ~busy};
        end
    end

    // Operands travel alongside the three sine and cosine stages.
    always_ff @(posedge i_clk) begin
        r_kind <= {r_kind[1:0], i_kind};
        r_a[0] <= i_first_in;
        r_b[0] <= i_second_in;
        r_a[1] <= r_a[0];
        r_b[1] <= r_b[0];
        r_a[2] <= r_a[1];
        r_b[2] <= r_b[1];
    end

    always_ff @(posedge i_clk) begin
        r_kind4 <= r_kind[2];
        r_ac    <= r_a[2] * w_cos;
        r_bs    <= r_b[2] * w_sin;
        r_as    <= r_a[2] * w_sin;
        r_bc    <= r_b[2] * w_cos;
    end

    always_comb begin
        if (!r_kind4) begin
            n_sum_first  = 34'(r_ac) + 34'(r_bs);
            n_sum_second = 34'(r_bc) - 34'(r_as);
        end else begin
            n_sum_first  = 34'(r_ac) - 34'(r_bs);
            n_sum_second = 34'(r_as) + 34'(r_bc);
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= pipt_pkg::scale_sat(n_sum_first);
        r_second <= pipt_pkg::scale_sat(n_sum_second);
    end

    assign o_valid      = r_vld[4];
    assign o_first_out  = r_first;
    assign o_second_out = r_second;

    `PIPT_ASSERT_ALWAYS(a_never_busy, !busy, "busy asserted")
    `PIPT_ASSERT_NEXT(a_accept_enters, start, r_vld[0], "accepted transfer not captured")
    `PIPT_ASSERT_NEXT(a_reach_output, r_vld[3], o_valid, "valid lost before output")

endmodule

// ===== design/pipt_sincos.sv =====
// Three-stage interpolated Q15 sine lookup over a 15-bit angle.
module pipt_sincos (
    input  logic                i_clk,
    input  logic [14:0]         i_angle,
    output pipt_pkg::t_q15      o_value
);

    logic [7:0]         w_idx;
    logic signed [16:0] w_diff;
    logic signed [8:0]  n_step;

    logic signed [15:0] r_base1;
    logic signed [8:0]  r_step1;
    logic [6:0]         r_frac1;
    logic signed [15:0] r_base2;
    logic signed [15:0] r_prod2;
    pipt_pkg::t_q15     r_value3;

    assign w_idx = i_angle[14:7];

    always_comb begin
        w_diff = $signed({pipt_pkg::SINE_ROM[{1'b0, w_idx} + 9'd1][15],
                          pipt_pkg::SINE_ROM[{1'b0, w_idx} + 9'd1]})
               - $signed({pipt_pkg::SINE_ROM[{1'b0, w_idx}][15],
                          pipt_pkg::SINE_ROM[{1'b0, w_idx}]});
        if (w_diff > pipt_pkg::STEP_LIMIT) begin
            n_step = pipt_pkg::STEP_LIMIT[8:0];
        end else if (w_diff < -pipt_pkg::STEP_LIMIT) begin
            n_step = 9'sh101;
        end else begin
            n_step = w_diff[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_base1  <= $signed(pipt_pkg::SINE_ROM[{1'b0, w_idx}]);
        r_step1  <= n_step;
        r_frac1  <= i_angle[6:0];
        r_base2  <= r_base1;
        r_prod2  <= 16'(r_step1 * $signed({1'b0, r_frac1}));
        r_value3 <= r_base2 + (r_prod2 >>> 7);
    end

    assign o_value = r_value3;

endmodule
